// File: sv/psalu_pkg.sv
// Shared definitions for the packed SIMD integer ALU: operation and lane
// size codes plus the pipeline latency constant. No dependencies.
package psalu_pkg;

  localparam int unsigned VEC_W = 64;

  typedef logic [2:0] op_t;
  typedef logic [1:0] lsize_t;

  localparam op_t OP_ADD  = 3'd0;
  localparam op_t OP_SUB  = 3'd1;
  localparam op_t OP_MUL  = 3'd2;
  localparam op_t OP_DIV  = 3'd3;
  localparam op_t OP_MADD = 3'd4;
  localparam op_t OP_NEG  = 3'd5;

  localparam lsize_t SZ_8  = 2'd0;
  localparam lsize_t SZ_16 = 2'd1;
  localparam lsize_t SZ_32 = 2'd2;
  localparam lsize_t SZ_64 = 2'd3;

  // Cycles from the input register to the aligned result tap.
  localparam int unsigned DIV_LAT = VEC_W + 2;

endpackage

// File: sv/packed_simd_integer_alu_core.sv
// Top level of the packed SIMD integer ALU: input register, lane adders,
// multiplier, per-lane dividers and the aligning delay line.
// Depends on psalu_pkg, psalu_mul and psalu_div.
//
// Fully pipelined: one item may be started every cycle, busy is always low,
// and each result appears with out_strobe after its start transfer. The
// pipeline depth is set by the 64-stage divider of the full-width
// lane (one quotient bit per stage plus sign handling); every operation runs
// through a delay line of the same length, so results leave in order. The
// receiver cannot stall; results are never held back.
module packed_simd_integer_alu_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psalu_pkg::op_t      in_op,
  input  psalu_pkg::lsize_t   in_lane_size,
  input  logic [63:0]         in_vec_a,
  input  logic [63:0]         in_vec_b,
  input  logic [63:0]         in_vec_c,
  output logic                out_strobe,
  output logic [63:0]         out_vec_result,
  output logic                out_div_zero
);
  import psalu_pkg::*;

  localparam int unsigned ALU_LINE = DIV_LAT - 3;

  function automatic logic [63:0] lane_addsub(logic [63:0] a, logic [63:0] b,
                                              lsize_t sz, logic sub);
    logic [63:0] r;
    r = '0;
    case (sz)
      SZ_8:  for (int k = 0; k < 8; k++)
               r[k*8 +: 8] = sub ? a[k*8 +: 8] - b[k*8 +: 8] : a[k*8 +: 8] + b[k*8 +: 8];
      SZ_16: for (int k = 0; k < 4; k++)
               r[k*16 +: 16] = sub ? a[k*16 +: 16] - b[k*16 +: 16]
                                   : a[k*16 +: 16] + b[k*16 +: 16];
      SZ_32: for (int k = 0; k < 2; k++)
               r[k*32 +: 32] = sub ? a[k*32 +: 32] - b[k*32 +: 32]
                                   : a[k*32 +: 32] + b[k*32 +: 32];
      default: r = sub ? a - b : a + b;
    endcase
    return r;
  endfunction

  logic        vld_s0_r;
  op_t         op_s0_r;
  lsize_t      sz_s0_r;
  logic [63:0] a_s0_r, b_s0_r, c_s0_r;

  logic        vld_r [DIV_LAT];
  op_t         op_r  [DIV_LAT];
  lsize_t      sz_r  [DIV_LAT];

  logic [63:0] arith_nxt, arith1_r, arith2_r;
  logic [63:0] a1_r, a2_r;
  logic [63:0] mul_y, prod;
  logic [63:0] alu_nxt, alu_r;
  logic [63:0] line_r [ALU_LINE];

  logic [63:0] q8, q16, q32, q64;
  logic [7:0]  z8;
  logic [3:0]  z16;
  logic [1:0]  z32;
  logic        z64;

  logic [63:0] res_nxt, res_r;
  logic        dz_nxt, dz_r, strobe_r;

  assign busy = 1'b0;

  // Capture each start transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s0_r <= 1'b0;
    end else begin
      vld_s0_r <= start;
    end
    op_s0_r <= in_op;
    sz_s0_r <= in_lane_size;
    a_s0_r  <= in_vec_a;
    b_s0_r  <= in_vec_b;
    c_s0_r  <= in_vec_c;
  end

  // Advance valid and control along the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= vld_s0_r;
      for (int k = 1; k < DIV_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
    op_r[0] <= op_s0_r;
    sz_r[0] <= sz_s0_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      op_r[k] <= op_r[k-1];
      sz_r[k] <= sz_r[k-1];
    end
  end

  // Add, subtract and negate
  always_comb begin
    if (op_s0_r == OP_NEG) begin
      arith_nxt = lane_addsub(64'd0, a_s0_r, sz_s0_r, 1'b1);
    end else begin
      arith_nxt = lane_addsub(a_s0_r, b_s0_r, sz_s0_r, op_s0_r == OP_SUB);
    end
  end

  always_ff @(posedge clk) begin
    arith1_r <= arith_nxt;
    arith2_r <= arith1_r;
    a1_r     <= a_s0_r;
    a2_r     <= a1_r;
  end

  // Multiply a*b, or b*c for multiply-add
  assign mul_y = (op_s0_r == OP_MADD) ? c_s0_r : a_s0_r;

  psalu_mul u_mul (
    .clk       (clk),
    .lane_size (sz_s0_r),
    .mul_x     (b_s0_r),
    .mul_y     (mul_y),
    .prod      (prod)
  );

  // Pick the non-divide result
  always_comb begin
    case (op_r[1]) inside
      OP_ADD, OP_SUB, OP_NEG: alu_nxt = arith2_r;
      OP_MUL:                 alu_nxt = prod;
      OP_MADD:                alu_nxt = lane_addsub(a2_r, prod, sz_r[1], 1'b0);
      default:                alu_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    alu_r     <= alu_nxt;
    line_r[0] <= alu_r;
    for (int k = 1; k < ALU_LINE; k++) line_r[k] <= line_r[k-1];
  end

  // Per-lane dividers for every lane size
  for (genvar k = 0; k < 8; k++) begin : g_d8
    psalu_div #(.W(8), .LAT(DIV_LAT)) u_div (
      .clk(clk), .dvd_in(a_s0_r[k*8 +: 8]), .dsr_in(b_s0_r[k*8 +: 8]),
      .quo(q8[k*8 +: 8]), .dz(z8[k]));
  end
  for (genvar k = 0; k < 4; k++) begin : g_d16
    psalu_div #(.W(16), .LAT(DIV_LAT)) u_div (
      .clk(clk), .dvd_in(a_s0_r[k*16 +: 16]), .dsr_in(b_s0_r[k*16 +: 16]),
      .quo(q16[k*16 +: 16]), .dz(z16[k]));
  end
  for (genvar k = 0; k < 2; k++) begin : g_d32
    psalu_div #(.W(32), .LAT(DIV_LAT)) u_div (
      .clk(clk), .dvd_in(a_s0_r[k*32 +: 32]), .dsr_in(b_s0_r[k*32 +: 32]),
      .quo(q32[k*32 +: 32]), .dz(z32[k]));
  end
  psalu_div #(.W(64), .LAT(DIV_LAT)) u_div64 (
    .clk(clk), .dvd_in(a_s0_r), .dsr_in(b_s0_r), .quo(q64), .dz(z64));

  // Merge divide and ALU results at the aligned tap
  always_comb begin
    res_nxt = line_r[ALU_LINE-1];
    dz_nxt  = 1'b0;
    if (op_r[DIV_LAT-1] == OP_DIV) begin
      case (sz_r[DIV_LAT-1])
        SZ_8:    begin res_nxt = q8;  dz_nxt = |z8;  end
        SZ_16:   begin res_nxt = q16; dz_nxt = |z16; end
        SZ_32:   begin res_nxt = q32; dz_nxt = |z32; end
        default: begin res_nxt = q64; dz_nxt = z64;  end
      endcase
    end
  end

  // Register the result; raise the zero-divisor flag only with a valid item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_r[DIV_LAT-1];
    end
    res_r <= res_nxt;
    dz_r  <= dz_nxt & vld_r[DIV_LAT-1];
  end

  assign out_strobe     = strobe_r;
  assign out_vec_result = res_r;
  assign out_div_zero   = dz_r;

`ifndef ASSERT_OFF
  a_strobe_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, DIV_LAT + 2))
    else $error("result transfer without matching start");
  a_dz_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_div_zero |-> out_strobe)
    else $error("div_zero raised outside a result transfer");
  a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_div_zero |-> $past(in_op, DIV_LAT + 2) == OP_DIV)
    else $error("div_zero raised for a non-divide operation");
  a_bad_op_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_op, DIV_LAT + 2) > OP_NEG) |-> out_vec_result == 64'd0)
    else $error("undefined operation gave nonzero result");
`endif

endmodule

// File: sv/psalu_mul.sv
// Two-stage packed lane multiplier (low half of each lane product).
// Depends on psalu_pkg.
module psalu_mul (
  input  logic                  clk,
  input  psalu_pkg::lsize_t     lane_size,
  input  logic [63:0]           mul_x,
  input  logic [63:0]           mul_y,
  output logic [63:0]           prod
);
  import psalu_pkg::*;

  logic [7:0]  p8_r  [8];
  logic [15:0] p16_r [4];
  logic [31:0] p32_r [2];
  logic [63:0] ll_r;
  logic [31:0] lh_r, hl_r;
  lsize_t      size_r;
  logic [63:0] prod_nxt, prod_r;

  // Stage one: narrow partial products, each at most 32 by 32
  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) p8_r[k] <= 8'(mul_x[k*8 +: 8] * mul_y[k*8 +: 8]);
    for (int k = 0; k < 4; k++) p16_r[k] <= 16'(mul_x[k*16 +: 16] * mul_y[k*16 +: 16]);
    for (int k = 0; k < 2; k++) p32_r[k] <= 32'(mul_x[k*32 +: 32] * mul_y[k*32 +: 32]);
    ll_r   <= 64'(mul_x[31:0]) * 64'(mul_y[31:0]);
    lh_r   <= 32'(mul_x[31:0] * mul_y[63:32]);
    hl_r   <= 32'(mul_x[63:32] * mul_y[31:0]);
    size_r <= lane_size;
  end

  // Stage two: assemble lanes, fold cross terms for the full-width lane
  always_comb begin
    prod_nxt = '0;
    case (size_r)
      SZ_8:    for (int k = 0; k < 8; k++) prod_nxt[k*8 +: 8] = p8_r[k];
      SZ_16:   for (int k = 0; k < 4; k++) prod_nxt[k*16 +: 16] = p16_r[k];
      SZ_32:   for (int k = 0; k < 2; k++) prod_nxt[k*32 +: 32] = p32_r[k];
      default: prod_nxt = ll_r + {lh_r + hl_r, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// File: sv/psalu_div.sv
// Pipelined restoring divider for one signed lane, one quotient bit per
// stage, padded to a fixed latency. Depends on psalu_pkg.
module psalu_div #(
  parameter int unsigned W   = 8,
  parameter int unsigned LAT = psalu_pkg::DIV_LAT
) (
  input  logic         clk,
  input  logic [W-1:0] dvd_in,
  input  logic [W-1:0] dsr_in,
  output logic [W-1:0] quo,
  output logic         dz
);
  import psalu_pkg::*;

  localparam int unsigned PAD = LAT - W - 2;

  logic [W-1:0] rem_r [W+1];
  logic [W-1:0] dvd_r [W+1];
  logic [W-1:0] dsr_r [W+1];
  logic         neg_r [W+1];
  logic         zro_r [W+1];
  logic [W-1:0] q_r;
  logic         z_r;

  // Take magnitudes and note the quotient sign
  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    dvd_r[0] <= dvd_in[W-1] ? W'(-dvd_in) : dvd_in;
    dsr_r[0] <= dsr_in[W-1] ? W'(-dsr_in) : dsr_in;
    neg_r[0] <= dvd_in[W-1] ^ dsr_in[W-1];
    zro_r[0] <= (dsr_in == '0);
  end

  // One trial subtraction per stage
  for (genvar i = 1; i <= W; i++) begin : g_step
    logic [W:0] trial;
    assign trial = {rem_r[i-1], dvd_r[i-1][W-1]} - {1'b0, dsr_r[i-1]};
    always_ff @(posedge clk) begin
      if (!trial[W]) begin
        rem_r[i] <= trial[W-1:0];
      end else begin
        rem_r[i] <= {rem_r[i-1][W-2:0], dvd_r[i-1][W-1]};
      end
      dvd_r[i] <= {dvd_r[i-1][W-2:0], ~trial[W]};
      dsr_r[i] <= dsr_r[i-1];
      neg_r[i] <= neg_r[i-1];
      zro_r[i] <= zro_r[i-1];
    end
  end

  // Restore the sign; a zero divisor gives zero
  always_ff @(posedge clk) begin
    if (zro_r[W]) begin
      q_r <= '0;
    end else begin
      q_r <= neg_r[W] ? W'(-dvd_r[W]) : dvd_r[W];
    end
    z_r <= zro_r[W];
  end

  // Pad to the common latency
  if (PAD > 0) begin : g_pad
    logic [W-1:0] qd_r [PAD];
    logic         zd_r [PAD];
    always_ff @(posedge clk) begin
      qd_r[0] <= q_r;
      zd_r[0] <= z_r;
      for (int k = 1; k < PAD; k++) begin
        qd_r[k] <= qd_r[k-1];
        zd_r[k] <= zd_r[k-1];
      end
    end
    assign quo = qd_r[PAD-1];
    assign dz  = zd_r[PAD-1];
  end else begin : g_nopad
    assign quo = q_r;
    assign dz  = z_r;
  end

endmodule
